// ===== rtl/core/xalu_pkg.sv =====
// Shared types, command codes and width helpers for the x86 integer ALU subset.
package xalu_pkg;

  localparam logic [4:0] CMD_MOV    = 5'd0;
  localparam logic [4:0] CMD_MOVSX  = 5'd1;
  localparam logic [4:0] CMD_MOVZX  = 5'd2;
  localparam logic [4:0] CMD_MOVSXD = 5'd3;
  localparam logic [4:0] CMD_ADD    = 5'd4;
  localparam logic [4:0] CMD_INC    = 5'd5;
  localparam logic [4:0] CMD_SUB    = 5'd6;
  localparam logic [4:0] CMD_CMP    = 5'd7;
  localparam logic [4:0] CMD_IMUL   = 5'd8;
  localparam logic [4:0] CMD_AND    = 5'd9;
  localparam logic [4:0] CMD_OR     = 5'd10;
  localparam logic [4:0] CMD_XOR    = 5'd11;
  localparam logic [4:0] CMD_TEST   = 5'd12;
  localparam logic [4:0] CMD_SHL    = 5'd13;
  localparam logic [4:0] CMD_CDQE   = 5'd14;
  localparam logic [4:0] CMD_JMP    = 5'd15;
  localparam logic [4:0] CMD_JE     = 5'd16;
  localparam logic [4:0] CMD_JNE    = 5'd17;
  localparam logic [4:0] CMD_JBE    = 5'd18;
  localparam logic [4:0] CMD_JL     = 5'd19;
  localparam logic [4:0] CMD_JLE    = 5'd20;

  localparam logic [1:0] W_BYTE  = 2'd0;
  localparam logic [1:0] W_WORD  = 2'd1;
  localparam logic [1:0] W_DWORD = 2'd2;
  localparam logic [1:0] W_QWORD = 2'd3;

  // flag bit positions
  localparam int unsigned F_CF = 0;
  localparam int unsigned F_ZF = 1;
  localparam int unsigned F_SF = 2;
  localparam int unsigned F_OF = 3;

  typedef struct packed {
    logic [4:0]  cmd;
    logic [1:0]  op_width;
    logic        dest_is_register;
    logic [1:0]  src_width;
    logic [63:0] dest_value;
    logic [63:0] src_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result;
    logic        write_back;
    logic        branch_taken;
    logic [3:0]  flags_out;
  } out_item_t;

  // execute stage output, held in the middle pipeline register
  typedef struct packed {
    logic [63:0] res;
    logic [63:0] dest;
    logic        wb;
    logic        is_mul;
    logic [1:0]  op_width;
    logic        dest_reg;
    logic [4:0]  cmd;
    logic        flags_we;
    logic [3:0]  flags_new;
  } exec_t;

  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
  } mul_part_t;

  function automatic logic [63:0] width_mask(input logic [1:0] w);
    logic [63:0] m;
    case (w)
      W_BYTE:  m = 64'h0000_0000_0000_00FF;
      W_WORD:  m = 64'h0000_0000_0000_FFFF;
      W_DWORD: m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] sign_bit(input logic [1:0] w);
    logic [63:0] b;
    case (w)
      W_BYTE:  b = 64'h0000_0000_0000_0080;
      W_WORD:  b = 64'h0000_0000_0000_8000;
      W_DWORD: b = 64'h0000_0000_8000_0000;
      default: b = 64'h8000_0000_0000_0000;
    endcase
    return b;
  endfunction

  function automatic logic [63:0] sign_ext(input logic [63:0] v, input logic [1:0] w);
    logic [63:0] r;
    case (w)
      W_BYTE:  r = {{56{v[7]}}, v[7:0]};
      W_WORD:  r = {{48{v[15]}}, v[15:0]};
      W_DWORD: r = {{32{v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  // write-back merge: dword to a register zero-extends, narrower keeps upper dest bits
  function automatic logic [63:0] merge(input logic [63:0] dest, input logic [63:0] val,
                                        input logic [1:0] w, input logic reg_dst);
    logic [63:0] m;
    logic [63:0] r;
    m = width_mask(w);
    if (w == W_QWORD) begin
      r = val;
    end else if (w == W_DWORD && reg_dst) begin
      r = val & m;
    end else begin
      r = (dest & ~m) | (val & m);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/xalu_mul.sv =====
// Registered 32x32 partial products for the low half of a 64x64 multiply.
module xalu_mul (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [63:0]           a_i,
  input  logic [63:0]           b_i,
  output xalu_pkg::mul_part_t   part_o
);

  xalu_pkg::mul_part_t part_d, part_q;

  always_comb begin
    part_d.ll = {32'd0, a_i[31:0]} * {32'd0, b_i[31:0]};
    // only the low 32 bits of the cross terms reach the low 64-bit product
    part_d.lh = a_i[31:0] * b_i[63:32];
    part_d.hl = a_i[63:32] * b_i[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      part_q <= part_d;
    end
  end

  assign part_o = part_q;

endmodule

// ===== rtl/core/xalu_exec.sv =====
// Execute logic: results for all non-multiply commands and compare/test flags.
module xalu_exec (
  input  xalu_pkg::in_item_t item_i,
  output xalu_pkg::exec_t    exec_o
);

  logic [63:0] d, s, m, sb;
  logic [63:0] val;
  logic [63:0] ca, cb, cr, tr;
  logic [5:0]  cnt;

  always_comb begin
    d   = item_i.dest_value;
    s   = item_i.src_value;
    m   = xalu_pkg::width_mask(item_i.op_width);
    sb  = xalu_pkg::sign_bit(item_i.op_width);
    cnt = (item_i.op_width == xalu_pkg::W_QWORD) ? s[5:0] : {1'b0, s[4:0]};
    ca  = d & m;
    cb  = s & m;
    cr  = (ca - cb) & m;
    tr  = d & s;

    val = s;
    exec_o.wb        = 1'b1;
    exec_o.is_mul    = 1'b0;
    exec_o.flags_we  = 1'b0;
    exec_o.flags_new = '0;

    case (item_i.cmd)
      xalu_pkg::CMD_MOV:    val = s;
      xalu_pkg::CMD_MOVSX:  val = xalu_pkg::sign_ext(s, item_i.src_width);
      xalu_pkg::CMD_MOVZX:  val = s & xalu_pkg::width_mask(item_i.src_width);
      xalu_pkg::CMD_MOVSXD: val = xalu_pkg::sign_ext(s, xalu_pkg::W_DWORD);
      xalu_pkg::CMD_ADD:    val = d + s;
      xalu_pkg::CMD_INC:    val = d + 64'd1;
      xalu_pkg::CMD_SUB:    val = d - s;
      xalu_pkg::CMD_IMUL:   exec_o.is_mul = 1'b1;
      xalu_pkg::CMD_AND:    val = d & s;
      xalu_pkg::CMD_OR:     val = d | s;
      xalu_pkg::CMD_XOR:    val = d ^ s;
      xalu_pkg::CMD_SHL:    val = ca << cnt;
      xalu_pkg::CMD_CDQE:   val = s;
      xalu_pkg::CMD_CMP: begin
        exec_o.wb                   = 1'b0;
        exec_o.flags_we             = 1'b1;
        exec_o.flags_new[xalu_pkg::F_CF] = ca < cb;
        exec_o.flags_new[xalu_pkg::F_ZF] = cr == 64'd0;
        exec_o.flags_new[xalu_pkg::F_SF] = (cr & sb) != 64'd0;
        exec_o.flags_new[xalu_pkg::F_OF] = (((ca ^ cb) & (ca ^ cr)) & sb) != 64'd0;
      end
      xalu_pkg::CMD_TEST: begin
        exec_o.wb                   = 1'b0;
        exec_o.flags_we             = 1'b1;
        exec_o.flags_new[xalu_pkg::F_ZF] = (tr & m) == 64'd0;
        exec_o.flags_new[xalu_pkg::F_SF] = (tr & sb) != 64'd0;
      end
      default: exec_o.wb = 1'b0; // jumps and unused codes
    endcase

    if (item_i.cmd == xalu_pkg::CMD_CDQE) begin
      exec_o.res = xalu_pkg::sign_ext(d, xalu_pkg::W_DWORD);
    end else if (exec_o.wb) begin
      exec_o.res = xalu_pkg::merge(d, val, item_i.op_width, item_i.dest_is_register);
    end else begin
      exec_o.res = d;
    end

    exec_o.dest     = d;
    exec_o.op_width = item_i.op_width;
    exec_o.dest_reg = item_i.dest_is_register;
    exec_o.cmd      = item_i.cmd;
  end

endmodule

// ===== rtl/core/x86_integer_alu_subset_unit.sv =====
// Pipeline: input, execute and result registers. Throughput: one item per cycle
// while the result register is free or being taken; the multiply is split into
// registered 32x32 partial products in the execute stage and summed in the result stage.
// Stored flags update as an item enters the result register, in item order.
// Reset (rst_ni low, async) clears all stage valids and the stored flags.
module x86_integer_alu_subset_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  xalu_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output xalu_pkg::out_item_t  out_data_o
);

  logic                 en;
  logic                 s0_valid_q, s1_valid_q, out_valid_q;
  xalu_pkg::in_item_t   s0_q;
  xalu_pkg::exec_t      exec_d, s1_q;
  xalu_pkg::mul_part_t  part;
  xalu_pkg::out_item_t  out_d, out_q;
  logic [3:0]           flags_d, flags_q;
  logic [63:0]          prod;
  logic                 lt;

  // whole pipe advances when the result register is free or being taken
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  xalu_exec u_exec (
    .item_i (s0_q),
    .exec_o (exec_d)
  );

  xalu_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (s0_q.dest_value),
    .b_i    (s0_q.src_value),
    .part_o (part)
  );

  always_comb begin
    prod    = part.ll + {part.lh + part.hl, 32'd0};
    flags_d = s1_q.flags_we ? s1_q.flags_new : flags_q;
    lt      = flags_q[xalu_pkg::F_SF] != flags_q[xalu_pkg::F_OF];

    out_d.result     = s1_q.is_mul ? xalu_pkg::merge(s1_q.dest, prod, s1_q.op_width,
                                                     s1_q.dest_reg)
                                   : s1_q.res;
    out_d.write_back = s1_q.wb;
    out_d.flags_out  = flags_d;
    case (s1_q.cmd)
      xalu_pkg::CMD_JMP: out_d.branch_taken = 1'b1;
      xalu_pkg::CMD_JE:  out_d.branch_taken = flags_q[xalu_pkg::F_ZF];
      xalu_pkg::CMD_JNE: out_d.branch_taken = !flags_q[xalu_pkg::F_ZF];
      xalu_pkg::CMD_JBE: out_d.branch_taken = flags_q[xalu_pkg::F_CF] | flags_q[xalu_pkg::F_ZF];
      xalu_pkg::CMD_JL:  out_d.branch_taken = lt;
      xalu_pkg::CMD_JLE: out_d.branch_taken = flags_q[xalu_pkg::F_ZF] | lt;
      default:           out_d.branch_taken = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else if (en) begin
      s0_valid_q  <= in_valid_i;
      s1_valid_q  <= s0_valid_q;
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        flags_q <= flags_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q  <= in_data_i;
      s1_q  <= exec_d;
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
